// ===== hw/rtl/g2r_pkg.sv =====
// Package for the glob-to-regex translator: parser mode enum, status codes,
// character constants and the expansion record passed from translator to serializer.
// No dependencies.
`default_nettype none

package g2r_pkg;

    typedef enum logic [1:0] {
        MODE_TOP     = 2'd0,
        MODE_BRACE   = 2'd1,
        MODE_BRACKET = 2'd2
    } g2r_mode_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NESTED    = 2'd1;
    localparam logic [1:0] ST_PREMATURE = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_END  = 1'b1;

    localparam int MAX_BEATS = 6;
    localparam int CNT_W     = $clog2(MAX_BEATS + 1);

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_NUL    = 8'h00;

    typedef struct packed {
        logic [MAX_BEATS-1:0][7:0] bytes;
        logic [CNT_W-1:0]          count;
        logic                      has_char;
        logic [1:0]                status;
    } g2r_exp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/g2r_in_if.sv =====
// Input channel of the glob-to-regex translator: valid/ready plus one pattern beat.
// No dependencies.
`default_nettype none

interface g2r_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] char_in;

    modport source (output valid, output command, output char_in, input ready);
    modport sink   (input valid, input command, input char_in, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/g2r_out_if.sv =====
// Output channel of the glob-to-regex translator: valid/ready plus one result beat.
// No dependencies.
`default_nettype none

interface g2r_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       has_char;
    logic       last_of_run;
    logic [1:0] status;

    modport source (output valid, output out_char, output has_char, output last_of_run,
                    output status, input ready);
    modport sink   (input valid, input out_char, input has_char, input last_of_run,
                    input status, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/g2r_xlate.sv =====
// Translator core: parser state registers and the combinational expansion of one
// input beat into up to six result bytes. Depends on g2r_pkg.
`default_nettype none

module g2r_xlate
    import g2r_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic       command,
    input  wire logic [7:0] char_in,
    output g2r_exp_t        expansion
);

    g2r_mode_t  mode_reg, mode_next;
    logic       esc_reg, esc_next;
    logic [1:0] alt_reg, alt_next;
    logic       opt_reg, opt_next;
    logic       held_reg, held_next;
    logic       seen_reg, seen_next;
    logic [1:0] err_reg, err_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_TOP;
            esc_reg  <= 1'b0;
            alt_reg  <= 2'd0;
            opt_reg  <= 1'b0;
            held_reg <= 1'b0;
            seen_reg <= 1'b0;
            err_reg  <= ST_OK;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            esc_reg  <= esc_next;
            alt_reg  <= alt_next;
            opt_reg  <= opt_next;
            held_reg <= held_next;
            seen_reg <= seen_next;
            err_reg  <= err_next;
        end
    end

    always_comb
    begin
        logic [MAX_BEATS-2:0][7:0] b;
        logic [2:0]                n;
        logic                      hold_new;
        logic                      bar;

        b        = '0;
        n        = 3'd0;
        hold_new = 1'b0;
        bar      = 1'b0;

        mode_next = mode_reg;
        esc_next  = esc_reg;
        alt_next  = alt_reg;
        opt_next  = opt_reg;
        held_next = held_reg;
        seen_next = seen_reg;
        err_next  = err_reg;

        expansion          = '0;
        expansion.has_char = 1'b1;
        expansion.status   = ST_OK;

        if (command == CMD_END)
        begin
            expansion.count    = CNT_W'(1);
            expansion.has_char = 1'b0;
            if (err_reg != ST_OK)
                expansion.status = err_reg;
            else if (esc_reg || mode_reg != MODE_TOP)
                expansion.status = ST_PREMATURE;
            else if (!seen_reg)
                expansion.status = ST_EMPTY;
            else
                expansion.status = ST_OK;
            mode_next = MODE_TOP;
            esc_next  = 1'b0;
            alt_next  = 2'd0;
            opt_next  = 1'b0;
            held_next = 1'b0;
            seen_next = 1'b0;
            err_next  = ST_OK;
        end
        else
        begin
            seen_next = 1'b1;
            if (err_reg != ST_OK)
            begin
                n = 3'd0;
            end
            else if (esc_reg)
            begin
                esc_next = 1'b0;
                b[0]     = char_in;
                n        = 3'd1;
            end
            else
            begin
                if (mode_reg == MODE_BRACE && alt_reg < 2'd2)
                    alt_next = alt_reg + 2'd1;
                case (char_in)
                    CH_BSLASH:
                    begin
                        esc_next = 1'b1;
                        b[0]     = char_in;
                        n        = 3'd1;
                    end
                    CH_LBRACE:
                    begin
                        if (mode_reg == MODE_BRACE)
                        begin
                            err_next  = ST_NESTED;
                            held_next = 1'b0;
                        end
                        else if (mode_reg == MODE_TOP)
                        begin
                            b[0]      = CH_LPAREN;
                            b[1]      = CH_QUEST;
                            b[2]      = CH_COLON;
                            n         = 3'd3;
                            mode_next = MODE_BRACE;
                            alt_next  = 2'd0;
                            opt_next  = 1'b0;
                        end
                        else
                        begin
                            b[0] = char_in;
                            n    = 3'd1;
                        end
                    end
                    CH_RBRACE:
                    begin
                        if (mode_reg == MODE_BRACE)
                        begin
                            if (alt_next == 2'd1)
                            begin
                                opt_next  = 1'b1;
                                held_next = 1'b0;
                            end
                            b[0] = CH_RPAREN;
                            n    = 3'd1;
                            if (opt_next)
                            begin
                                b[1] = CH_QUEST;
                                n    = 3'd2;
                            end
                            mode_next = MODE_TOP;
                        end
                        else
                        begin
                            b[0] = char_in;
                            n    = 3'd1;
                        end
                    end
                    CH_LBRACK:
                    begin
                        if (mode_reg == MODE_TOP)
                            mode_next = MODE_BRACKET;
                        b[0] = char_in;
                        n    = 3'd1;
                    end
                    CH_RBRACK:
                    begin
                        if (mode_reg == MODE_BRACKET)
                            mode_next = MODE_TOP;
                        b[0] = char_in;
                        n    = 3'd1;
                    end
                    CH_COMMA:
                    begin
                        if (mode_reg == MODE_BRACE)
                        begin
                            if (alt_next == 2'd1)
                                opt_next = 1'b1;
                            else
                                hold_new = 1'b1;
                            alt_next = 2'd0;
                        end
                        else
                        begin
                            b[0] = char_in;
                            n    = 3'd1;
                        end
                    end
                    CH_CARET:
                    begin
                        if (mode_reg != MODE_BRACKET)
                        begin
                            b[0] = CH_BSLASH;
                            b[1] = char_in;
                            n    = 3'd2;
                        end
                        else
                        begin
                            b[0] = char_in;
                            n    = 3'd1;
                        end
                    end
                    CH_DOT, CH_PLUS, CH_LPAREN, CH_RPAREN, CH_DOLLAR:
                    begin
                        b[0] = CH_BSLASH;
                        b[1] = char_in;
                        n    = 3'd2;
                    end
                    CH_STAR:
                    begin
                        b[0] = CH_LBRACK;
                        b[1] = CH_CARET;
                        b[2] = CH_SLASH;
                        b[3] = CH_RBRACK;
                        b[4] = CH_STAR;
                        n    = 3'd5;
                    end
                    CH_QUEST:
                    begin
                        b[0] = CH_LBRACK;
                        b[1] = CH_CARET;
                        b[2] = CH_SLASH;
                        b[3] = CH_RBRACK;
                        n    = 3'd4;
                    end
                    default:
                    begin
                        b[0] = char_in;
                        n    = 3'd1;
                    end
                endcase
            end

            // A bar held from an earlier comma goes out ahead of the next emitted byte.
            if (held_next && (n != 3'd0 || hold_new))
            begin
                bar       = 1'b1;
                held_next = 1'b0;
            end
            if (hold_new)
                held_next = 1'b1;

            if (bar)
            begin
                expansion.bytes[0] = CH_BAR;
                for (int i = 1; i < MAX_BEATS; i++)
                    expansion.bytes[i] = b[i-1];
            end
            else
            begin
                for (int i = 0; i < MAX_BEATS - 1; i++)
                    expansion.bytes[i] = b[i];
                expansion.bytes[MAX_BEATS-1] = CH_NUL;
            end
            expansion.count = CNT_W'(n) + CNT_W'(bar);
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/g2r_serial.sv =====
// Result serializer: holds one expansion and shifts it out one beat per
// cycle while out_ready is high. Depends on g2r_pkg.
`default_nettype none

module g2r_serial
    import g2r_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       load,
    input  wire g2r_exp_t   expansion,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_char,
    output logic            has_char,
    output logic            last_of_run,
    output logic [1:0]      status
);

    logic [MAX_BEATS-1:0][7:0] bytes_reg, bytes_next;
    logic [CNT_W-1:0]          rem_reg, rem_next;
    logic                      has_reg, has_next;
    logic [1:0]                status_reg, status_next;
    logic                      fire;

    assign fire      = out_valid && out_ready;
    assign out_valid = (rem_reg != '0);
    assign in_ready  = (rem_reg == '0) || (out_ready && rem_reg == CNT_W'(1));

    assign out_char    = bytes_reg[0];
    assign has_char    = has_reg;
    assign status      = status_reg;
    assign last_of_run = (rem_reg == CNT_W'(1));

    always_comb
    begin
        bytes_next  = bytes_reg;
        rem_next    = rem_reg;
        has_next    = has_reg;
        status_next = status_reg;
        if (fire)
        begin
            bytes_next = {CH_NUL, bytes_reg[MAX_BEATS-1:1]};
            rem_next   = rem_reg - CNT_W'(1);
        end
        if (load)
        begin
            bytes_next  = expansion.bytes;
            rem_next    = expansion.count;
            has_next    = expansion.has_char;
            status_next = expansion.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rem_reg <= '0;
        else
            rem_reg <= rem_next;
    end

    always_ff @(posedge clk)
    begin
        bytes_reg  <= bytes_next;
        has_reg    <= has_next;
        status_reg <= status_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/glob_to_regex_translator.sv =====
// Top level of the glob-to-regex translator: translator core plus result serializer.
// Depends on g2r_pkg, g2r_in_if, g2r_out_if, g2r_xlate and g2r_serial.
//
// A glob pattern enters on in_ch one byte per beat (command 0), closed by an end
// beat (command 1). The regular expression leaves on out_ch one byte per beat.
// Each input beat gives zero to six result beats; the last one carries
// last_of_run. The end beat gives a single beat with has_char low that reports
// the status of the whole pattern; after it the parser is back at its initial
// state for the next pattern.
// The first result beat of an input is valid in the cycle after acceptance.
// A one-beat expansion sustains one input beat per cycle while out_ch.ready is
// high; a longer one holds the serializer until its beats are taken, and
// in_ch.ready stays low until its last beat is being taken. An input with no
// result leaves the serializer unloaded. While out_ch.ready is low the current
// beat holds and in_ch.ready drops once the serializer has no room. Reset
// empties the serializer and returns the parser to top level with no error set.
`default_nettype none

module glob_to_regex_translator
    import g2r_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    g2r_in_if.sink     in_ch,
    g2r_out_if.source  out_ch
);

    g2r_exp_t expansion;
    logic     in_ready;
    logic     accept;
    logic     load;

    assign in_ch.ready = in_ready;
    assign accept      = in_ch.valid && in_ready;
    assign load        = accept && (expansion.count != '0);

    g2r_xlate u_xlate (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .command   (in_ch.command),
        .char_in   (in_ch.char_in),
        .expansion (expansion)
    );

    g2r_serial u_serial (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load),
        .expansion   (expansion),
        .in_ready    (in_ready),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .out_char    (out_ch.out_char),
        .has_char    (out_ch.has_char),
        .last_of_run (out_ch.last_of_run),
        .status      (out_ch.status)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/g2r_checker.sv =====
// Port-level checker for the glob-to-regex translator, bound to the top level.
// Depends on g2r_pkg.
`default_nettype none

module g2r_checker
    import g2r_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_char,
    input wire logic       has_char,
    input wire logic       last_of_run,
    input wire logic [1:0] status
);

    a_char_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_char |-> status == ST_OK)
        else $error("Byte beat carries a nonzero status.");

    a_status_beat_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_char |-> last_of_run && out_char == CH_NUL)
        else $error("Status beat is not a lone zero beat.");

    a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("Input stalled with no result pending.");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(has_char)
            && $stable(last_of_run) && $stable(status))
        else $error("Stalled result beat changed.");

endmodule

bind glob_to_regex_translator g2r_checker u_g2r_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_char    (out_ch.out_char),
    .has_char    (out_ch.has_char),
    .last_of_run (out_ch.last_of_run),
    .status      (out_ch.status)
);

`default_nettype wire
